// ----- src/scrt_pkg.sv -----
// ----------------------------------------------------------------------------
// scrt_pkg: shared types and functions for the seeded crc32c triple hash
// Holds the field widths, the queue entry layout and the reflected
// Castagnoli CRC update used by the hash lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package scrt_pkg;

  // field widths
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 4;
  localparam int HASH_W  = 32;

  // defaults for the top-level parameters
  localparam int WORD_BYTES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // reflected CRC-32C polynomial
  localparam logic [HASH_W-1:0] CASTAGNOLI_POLY = 32'h82F6_3B78;

  // one classified key word between front and back
  typedef struct packed {
    logic [KEY_W-1:0]   key_bytes;
    logic [COUNT_W-1:0] byte_count;  // already saturated to the word size
    logic               last_word;
    logic               key_start;   // first word of a key: reload lanes
    logic [HASH_W-1:0]  seed;        // seed register value, used at key start
  } entry_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one byte through the reflected CRC, no inversion
  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc_in,
                                                 input logic [7:0] data);
    logic [HASH_W-1:0] crc;
    crc = crc_in ^ {{(HASH_W-8){1'b0}}, data};
    for (int b = 0; b < 8; b++) begin
      crc = crc[0] ? ((crc >> 1) ^ CASTAGNOLI_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // up to eight bytes, lowest first, only the first count bytes
  function automatic logic [HASH_W-1:0] crc_word(input logic [HASH_W-1:0] crc_in,
                                                 input logic [KEY_W-1:0] data,
                                                 input logic [COUNT_W-1:0] count);
    logic [HASH_W-1:0] crc;
    crc = crc_in;
    for (int i = 0; i < KEY_W / 8; i++) begin
      if (COUNT_W'(i) < count) begin
        crc = crc_byte(crc, data[8*i +: 8]);
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- src/scrt_front.sv -----
// ----------------------------------------------------------------------------
// scrt_front: input side of the triple hash
// Accepts key words, holds the seed register, marks key starts and
// saturates the byte count before handing words to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scrt_front #(
  parameter int WORD_BYTES = scrt_pkg::WORD_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [scrt_pkg::KEY_W-1:0]    in_key_bytes,
  input  wire logic [scrt_pkg::COUNT_W-1:0]  in_byte_count,
  input  wire logic                          in_last_word,
  input  wire logic                          cfg_wen,
  input  wire logic [scrt_pkg::HASH_W-1:0]   cfg_wdata,
  input  wire scrt_pkg::q_stat_t             q_stat,
  output logic                               push,
  output scrt_pkg::entry_t                   push_entry
);

  localparam logic [scrt_pkg::COUNT_W-1:0] MAX_COUNT = scrt_pkg::COUNT_W'(WORD_BYTES);

  logic [scrt_pkg::HASH_W-1:0] hash_seed_r, hash_seed_nxt;
  logic                        key_in_progress_r, key_in_progress_nxt;
  logic                        accept;

  // handshake toward the source
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept;

  // classify the word
  always_comb begin
    push_entry.key_bytes  = in_key_bytes;
    push_entry.byte_count = (in_byte_count > MAX_COUNT) ? MAX_COUNT : in_byte_count;
    push_entry.last_word  = in_last_word;
    push_entry.key_start  = !key_in_progress_r;
    push_entry.seed       = hash_seed_r;
  end

  // seed register and key tracking
  always_comb begin
    hash_seed_nxt       = cfg_wen ? cfg_wdata : hash_seed_r;
    key_in_progress_nxt = key_in_progress_r;
    if (accept) begin
      key_in_progress_nxt = !in_last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r       <= '0;
      key_in_progress_r <= 1'b0;
    end else begin
      hash_seed_r       <= hash_seed_nxt;
      key_in_progress_r <= key_in_progress_nxt;
    end
  end

  // checks
  a_last_ends_key: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_word) |=> !key_in_progress_r)
    else $error("key still in progress after last word");

  a_count_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.byte_count <= MAX_COUNT))
    else $error("byte count above word size reached the queue");

  a_mid_key_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last_word) |=> (push |-> !push_entry.key_start))
    else $error("key start flagged in the middle of a key");

endmodule

`default_nettype wire

// ----- src/scrt_queue.sv -----
// ----------------------------------------------------------------------------
// scrt_queue: short queue between front and back
// Register-based first-in first-out buffer; push and pop may happen in the
// same cycle, so a full stream passes at one word per cycle if the back pops.
// ----------------------------------------------------------------------------
`default_nettype none

module scrt_queue #(
  parameter int DEPTH = scrt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire scrt_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output scrt_pkg::entry_t       pop_entry,
  output scrt_pkg::q_stat_t      q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  scrt_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign pop_entry    = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ----- src/scrt_back.sv -----
// ----------------------------------------------------------------------------
// scrt_back: hash lanes and result register
// Pops one word per cycle while not stalled, updates the three CRC-32C lanes
// through an unrolled byte network, and registers the hashes on a last word.
// ----------------------------------------------------------------------------
`default_nettype none

module scrt_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire scrt_pkg::q_stat_t            q_stat,
  input  wire scrt_pkg::entry_t             pop_entry,
  output logic                              pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [scrt_pkg::HASH_W-1:0]       out_hash_from_seed,
  output logic [scrt_pkg::HASH_W-1:0]       out_hash_from_seed_next,
  output logic [scrt_pkg::HASH_W-1:0]       out_hash_from_seed_mix
);

  localparam int HW = scrt_pkg::HASH_W;

  logic [HW-1:0] lane_one_r, lane_two_r, lane_three_r;
  logic [HW-1:0] lane_one_nxt, lane_two_nxt, lane_three_nxt;
  logic [HW-1:0] base_one, base_two, base_three, seed_next;
  logic [HW-1:0] res_one_r, res_two_r, res_three_r;
  logic          out_valid_r, out_valid_nxt;

  // a last word waits only while an untaken result sits in the register
  assign pop = !q_stat.empty && (!pop_entry.last_word || !out_valid_r || out_tready);

  // lane start values or running values
  always_comb begin
    seed_next = pop_entry.seed + HW'(1);
    if (pop_entry.key_start) begin
      base_one   = pop_entry.seed;
      base_two   = seed_next;
      base_three = pop_entry.seed ^ seed_next;
    end else begin
      base_one   = lane_one_r;
      base_two   = lane_two_r;
      base_three = lane_three_r;
    end
    lane_one_nxt   = scrt_pkg::crc_word(base_one, pop_entry.key_bytes, pop_entry.byte_count);
    lane_two_nxt   = scrt_pkg::crc_word(base_two, pop_entry.key_bytes, pop_entry.byte_count);
    lane_three_nxt = scrt_pkg::crc_word(base_three, pop_entry.key_bytes,
                                        pop_entry.byte_count);
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (pop && pop_entry.last_word) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // lane and result registers
  always_ff @(posedge clk) begin
    if (pop) begin
      lane_one_r   <= lane_one_nxt;
      lane_two_r   <= lane_two_nxt;
      lane_three_r <= lane_three_nxt;
    end
    if (pop && pop_entry.last_word) begin
      res_one_r   <= lane_one_nxt;
      res_two_r   <= lane_two_nxt;
      res_three_r <= lane_three_nxt;
    end
  end

  assign out_tvalid              = out_valid_r;
  assign out_hash_from_seed      = res_one_r;
  assign out_hash_from_seed_next = res_two_r;
  assign out_hash_from_seed_mix  = res_three_r;

  // checks
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_entry.last_word) |=> out_valid_r)
    else $error("last word processed but no result shown");

  a_inner_word_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && !(pop && pop_entry.last_word)) |=> $stable(res_one_r))
    else $error("held result changed");

  a_held_result_blocks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(pop && pop_entry.last_word))
    else $error("last word taken while a result is held");

endmodule

`default_nettype wire

// ----- src/seeded_crc32c_triple_hash_core.sv -----
// ----------------------------------------------------------------------------
// seeded_crc32c_triple_hash_core: three-lane seeded CRC-32C key hash
// Hashes a key streamed as words of up to eight bytes with three reflected
// Castagnoli CRC lanes started from seed, seed+1 and their XOR.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tdata: key_bytes, byte_count; tlast: last_word
//   out_     out  tvalid / tready    tdata: three 32-bit hashes
//   cfg_     in   wen                wdata: hash_seed
//
// One word per cycle while no held result blocks a last word. With an empty
// queue a last word is written to the queue storage, then its lane update goes
// into the result register. The unrolled eight-byte CRC network sets the rate.
// A stalled output holds one result while words keep flowing until the queue
// fills. Reset is synchronous and clears the seed, the key state and the queue;
// the hash seed is sampled at the first word of each key.
// ----------------------------------------------------------------------------
`default_nettype none

module seeded_crc32c_triple_hash_core #(
  parameter int WORD_BYTES  = scrt_pkg::WORD_BYTES_DEF,
  parameter int QUEUE_DEPTH = scrt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // key_bytes [63:0], byte_count [67:64], zero [71:68]
  input  wire logic        in_tlast,
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // hash_from_seed, hash_from_seed_next, hash_from_seed_mix
  // seed register
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata
);

  localparam int KW = scrt_pkg::KEY_W;
  localparam int CW = scrt_pkg::COUNT_W;
  localparam int HW = scrt_pkg::HASH_W;

  logic              push, pop;
  scrt_pkg::entry_t  push_entry, pop_entry;
  scrt_pkg::q_stat_t q_stat;
  logic [HW-1:0]     hash_one, hash_two, hash_three;

  scrt_front #(
    .WORD_BYTES (WORD_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_key_bytes  (in_tdata[KW-1:0]),
    .in_byte_count (in_tdata[KW+CW-1:KW]),
    .in_last_word  (in_tlast),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  scrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  scrt_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_stat                  (q_stat),
    .pop_entry               (pop_entry),
    .pop                     (pop),
    .out_tvalid              (out_tvalid),
    .out_tready              (out_tready),
    .out_hash_from_seed      (hash_one),
    .out_hash_from_seed_next (hash_two),
    .out_hash_from_seed_mix  (hash_three)
  );

  // pack the result, first hash lowest
  assign out_tdata = {hash_three, hash_two, hash_one};

endmodule

`default_nettype wire

// ----- test/scrt_hash_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrt_hash_checker: result checker for the seeded crc32c triple hash core
// Watches the word, result and seed channels, keeps its own copy of the seed
// and the three CRC-32C lanes, and queues the hash triple for every accepted
// last word. Each accepted result is compared field by field with the oldest
// queued triple; mismatches and unexpected results count as failures.
// ----------------------------------------------------------------------------
module scrt_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,    // key_bytes [63:0], byte_count [67:64], zero [71:68]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,   // hash_from_seed, hash_from_seed_next, hash_from_seed_mix
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  localparam logic [31:0] CRC32C_REFL_POLY = 32'h82F6_3B78;
  localparam int          MAX_WORD_BYTES   = 8;

  typedef struct {
    logic [31:0] from_seed;
    logic [31:0] from_seed_next;
    logic [31:0] from_seed_mix;
  } hash_triple_t;

  hash_triple_t expected_hashes[$];
  logic [31:0]  seed_copy = '0;
  logic [31:0]  lane_crc[3];
  bit           key_open = 1'b0;
  int           errs = 0;

  // reflected crc-32c over one byte, lsb first, no inversion
  function automatic logic [31:0] crc32c_shift_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] r;
    r = crc ^ {24'd0, data};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC32C_REFL_POLY : 32'd0);
    return r;
  endfunction

  // advance the three lanes by one key word, queue a triple on the last one
  task automatic hash_key_word(logic [63:0] key, logic [3:0] cnt, logic last);
    int           n;
    hash_triple_t t;
    if (!key_open) begin
      lane_crc[0] = seed_copy;
      lane_crc[1] = seed_copy + 32'd1;
      lane_crc[2] = seed_copy ^ (seed_copy + 32'd1);
      key_open = 1'b1;
    end
    // counts above the word size saturate
    n = (cnt > MAX_WORD_BYTES) ? MAX_WORD_BYTES : int'(cnt);
    for (int i = 0; i < n; i++) begin
      for (int l = 0; l < 3; l++) begin
        lane_crc[l] = crc32c_shift_byte(lane_crc[l], key[8*i +: 8]);
      end
    end
    if (last) begin
      t.from_seed      = lane_crc[0];
      t.from_seed_next = lane_crc[1];
      t.from_seed_mix  = lane_crc[2];
      expected_hashes.push_back(t);
      key_open = 1'b0;
    end
  endtask

  task automatic compare_hash(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
      errs++;
    end
  endtask

  // compare one result item with the oldest queued triple
  task automatic check_result(logic [95:0] data);
    hash_triple_t e;
    if (expected_hashes.size() == 0) begin
      $display("%0t ns: result with nothing expected, expected none, actual %h",
               $time, data);
      errs++;
    end else begin
      e = expected_hashes.pop_front();
      compare_hash("hash_from_seed", e.from_seed, data[31:0]);
      compare_hash("hash_from_seed_next", e.from_seed_next, data[63:32]);
      compare_hash("hash_from_seed_mix", e.from_seed_mix, data[95:64]);
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_copy = '0;
      key_open  = 1'b0;
      expected_hashes.delete();
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) hash_key_word(in_tdata[63:0], in_tdata[67:64], in_tlast);
      if (cfg_wen) seed_copy = cfg_wdata;
    end
    outstanding <= expected_hashes.size();
    fail_count  <= errs;
  end

endmodule

// ----- test/seeded_crc32c_triple_hash_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_crc32c_triple_hash_core_tb: testbench for the triple hash core
// Drives key words and seed writes into the core with random gaps and
// random result back-pressure, including two long holds that fill the
// core and stall its input. A directed set covers empty keys, saturated
// byte counts, zero-count words inside a key, seed extremes and a seed
// change partway through a key; random multi-word keys follow.
// ----------------------------------------------------------------------------
module seeded_crc32c_triple_hash_core_tb;

  localparam int CLK_PERIOD       = 20;
  localparam int RANDOM_ITEMS     = 1450;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;    // key_bytes [63:0], byte_count [67:64], zero [71:68]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;   // hash_from_seed, hash_from_seed_next, hash_from_seed_mix
  logic        cfg_wen;
  logic [31:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int words_sent = 0;
  bit steady_flow = 1'b0;
  bit hold_req = 1'b0;

  seeded_crc32c_triple_hash_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  scrt_hash_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result back-pressure, with a long hold on request
  initial begin : result_sink
    int span;
    int r;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        span = LONG_HOLD_CYCLES;
      end else if (steady_flow || r < 55) begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 10);
      end else if (r < 92) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        span = $urandom_range(15, 60);
      end
      repeat (span) @(posedge clk);
    end
  end

  // offer one key word and hold it until accepted
  task automatic push_key_word(logic [63:0] key, logic [3:0] cnt, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, cnt, key};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering words and wait until every hash is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(logic [31:0] seed);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // one key, mostly full words, with occasional odd counts
  task automatic send_random_key();
    int         words;
    int         r;
    logic [3:0] cnt;
    words = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
    for (int w = 0; w < words; w++) begin
      r = $urandom_range(0, 99);
      if (w == words - 1) cnt = 4'($urandom_range(0, 8));
      else if (r < 85) cnt = 4'd8;
      else if (r < 93) cnt = 4'($urandom_range(1, 7));
      else cnt = 4'd0;
      if ($urandom_range(0, 19) == 0) cnt = 4'($urandom_range(9, 15));
      push_key_word({$urandom, $urandom}, cnt, w == words - 1);
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          random_start;
    int          r;
    logic [31:0] seed;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty key and data extremes at the reset seed
    push_key_word('0, 4'd0, 1'b1);
    push_key_word('1, 4'd8, 1'b1);
    push_key_word('0, 4'd8, 1'b1);
    // byte counts above the word size saturate
    push_key_word({$urandom, $urandom}, 4'd15, 1'b1);
    push_key_word({$urandom, $urandom}, 4'd9, 1'b1);
    // bytes above the count are ignored
    push_key_word('1, 4'd1, 1'b1);
    // zero-count word inside a key
    push_key_word({$urandom, $urandom}, 4'd3, 1'b0);
    push_key_word({$urandom, $urandom}, 4'd0, 1'b0);
    push_key_word({$urandom, $urandom}, 4'd8, 1'b0);
    push_key_word({$urandom, $urandom}, 4'd5, 1'b1);
    // empty last word closing a key
    push_key_word({$urandom, $urandom}, 4'd8, 1'b0);
    push_key_word({$urandom, $urandom}, 4'd0, 1'b1);
    // seed + 1 wraps to zero
    load_seed(32'hFFFF_FFFF);
    push_key_word('0, 4'd0, 1'b1);
    push_key_word('1, 4'd8, 1'b1);
    push_key_word({$urandom, $urandom}, 4'd7, 1'b1);
    load_seed(32'h8000_0000);
    push_key_word({$urandom, $urandom}, 4'd4, 1'b1);
    // new seed mid-key only applies from the next key
    push_key_word({$urandom, $urandom}, 4'd8, 1'b0);
    load_seed(32'h1234_5678);
    push_key_word({$urandom, $urandom}, 4'd6, 1'b1);
    push_key_word({$urandom, $urandom}, 4'd2, 1'b1);

    // random keys in phases, a fresh seed per phase
    phase = 0;
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hFFFF_FFFF;
        2:       seed = 32'h7FFF_FFFF;
        default: seed = $urandom;
      endcase
      load_seed(seed);
      if (phase == 2 || phase == 9) begin
        // long result hold while words keep coming
        hold_req = 1'b1;
        steady_flow = 1'b1;
        repeat (30) push_key_word({$urandom, $urandom}, 4'($urandom_range(0, 8)), 1'b1);
      end else begin
        steady_flow = (phase % 5 == 3);
        repeat ($urandom_range(8, 20)) send_random_key();
      end
      phase++;
    end
    steady_flow = 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
